// File: rtl/pig_pkg.sv
// ----------------------------------------------------------------------------
// pig_pkg
// Shared types and constants for the prime implicant generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pig_pkg;

    localparam int MAX_VARS_DEF   = 8;
    localparam int CUBE_DEPTH_DEF = 64;
    localparam int OUT_MAX        = 64;
    localparam int VAR_CFG_W      = 4;
    localparam logic [VAR_CFG_W-1:0] VAR_RESET = 4'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CMP,
        ST_LD_INS,
        ST_AFTER,
        ST_RD_I,
        ST_LAT_I,
        ST_RD_J,
        ST_CMP_J,
        ST_NX_RD,
        ST_NX_CMP,
        ST_NX_INS,
        ST_EM_RD,
        ST_EM_WR,
        ST_ROUND_END,
        ST_CP_RD,
        ST_CP_WR,
        ST_OUT_RD,
        ST_OUT_ST
    } pig_state_t;

endpackage

`default_nettype wire

// File: rtl/prime_implicant_generator.sv
// ----------------------------------------------------------------------------
// prime_implicant_generator
// Quine-McCluskey prime implicant generator with one shared cube comparator.
//
// Terms enter on start/busy: an item is taken when start is high and busy is
// low. Each term costs a scan of the cube store for a duplicate. An item with
// is_last runs the combining rounds: every pair of cubes is tried in the
// comparator, and each merge searches the next-round store for duplicates;
// copy and emit passes over the cubes follow. Primes are gathered in a prime
// buffer, then sent one at a time on result_valid, each shown for one cycle;
// the receiver cannot stall. last_prime marks the final prime, overflow is
// set on all primes of a run in which a store or the prime buffer ran out of
// room. busy stays high from the accepted item until the last prime is sent.
// var_count is written over cfg_valid/cfg_ready (always ready). Reset sets
// var_count to 4 and empties all stores at once.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_implicant_generator #(
    parameter int MAX_VARS   = pig_pkg::MAX_VARS_DEF,
    parameter int CUBE_DEPTH = pig_pkg::CUBE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [MAX_VARS-1:0]           term_value,
    input  wire logic                          is_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pig_pkg::VAR_CFG_W-1:0] cfg_data,
    output logic                               result_valid,
    output logic [MAX_VARS-1:0]                prime_value,
    output logic [MAX_VARS-1:0]                prime_mask,
    output logic                               last_prime,
    output logic                               overflow
);

    localparam int AW  = (CUBE_DEPTH > 1) ? $clog2(CUBE_DEPTH) : 1;
    localparam int CW  = $clog2(CUBE_DEPTH + 1);
    localparam int PAW = $clog2(pig_pkg::OUT_MAX);
    localparam int PCW = $clog2(pig_pkg::OUT_MAX + 1);
    localparam int KW  = (CW > PCW) ? CW : PCW;
    localparam int EW  = 2 * MAX_VARS;

    logic [EW-1:0] cur_mem   [CUBE_DEPTH];
    logic [EW-1:0] next_mem  [CUBE_DEPTH];
    logic [EW-1:0] prime_mem [pig_pkg::OUT_MAX];

    pig_pkg::pig_state_t state_reg, state_next;
    logic [pig_pkg::VAR_CFG_W-1:0] var_count_reg;
    logic [CW-1:0]  cur_count_reg, cur_count_next;
    logic [CW-1:0]  next_count_reg, next_count_next;
    logic [PCW-1:0] primes_reg, primes_next;
    logic           ovf_reg, ovf_next;
    logic [CUBE_DEPTH-1:0] merged_reg, merged_next;
    logic [CW-1:0]  i_reg, i_next, j_reg, j_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [MAX_VARS-1:0] term_reg, term_next;
    logic           last_reg, last_next;
    logic [EW-1:0]  a_reg, a_next;
    logic [EW-1:0]  cand_reg, cand_next;
    logic [EW-1:0]  cur_rd_reg, next_rd_reg, prime_rd_reg;

    logic [AW-1:0]  cur_raddr, cur_waddr, next_waddr;
    logic [PAW-1:0] prime_waddr;
    logic [EW-1:0]  cur_wdata, next_wdata, prime_wdata;
    logic           cur_we, next_we, prime_we;
    logic           out_fire;

    logic [MAX_VARS-1:0] vmask;
    logic [MAX_VARS-1:0] d;

    always_comb
    begin
        for (int b = 0; b < MAX_VARS; b++)
        begin
            vmask[b] = (b == 0) || (b < int'(var_count_reg));
        end
    end

    assign busy      = (state_reg != pig_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign d = a_reg[MAX_VARS-1:0] ^ cur_rd_reg[MAX_VARS-1:0];

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prime_we)
        begin
            prime_mem[prime_waddr] <= prime_wdata;
        end
        cur_rd_reg   <= cur_mem[cur_raddr];
        next_rd_reg  <= next_mem[k_reg[AW-1:0]];
        prime_rd_reg <= prime_mem[k_reg[PAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pig_pkg::ST_IDLE;
            var_count_reg  <= pig_pkg::VAR_RESET;
            cur_count_reg  <= '0;
            next_count_reg <= '0;
            primes_reg     <= '0;
            ovf_reg        <= 1'b0;
            merged_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            last_reg       <= 1'b0;
            result_valid   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_count_reg  <= cur_count_next;
            next_count_reg <= next_count_next;
            primes_reg     <= primes_next;
            ovf_reg        <= ovf_next;
            merged_reg     <= merged_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            last_reg       <= last_next;
            result_valid   <= out_fire;
            if (cfg_valid)
            begin
                var_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        a_reg    <= a_next;
        cand_reg <= cand_next;
        if (out_fire)
        begin
            prime_value <= prime_rd_reg[MAX_VARS-1:0];
            prime_mask  <= prime_rd_reg[EW-1:MAX_VARS];
            last_prime  <= (PCW'(k_reg) == primes_reg - PCW'(1));
            overflow    <= ovf_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_count_next  = cur_count_reg;
        next_count_next = next_count_reg;
        primes_next     = primes_reg;
        ovf_next        = ovf_reg;
        merged_next     = merged_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        term_next       = term_reg;
        last_next       = last_reg;
        a_next          = a_reg;
        cand_next       = cand_reg;
        cur_raddr       = k_reg[AW-1:0];
        cur_we          = 1'b0;
        cur_waddr       = cur_count_reg[AW-1:0];
        cur_wdata       = {{MAX_VARS{1'b0}}, term_reg};
        next_we         = 1'b0;
        next_waddr      = next_count_reg[AW-1:0];
        next_wdata      = cand_reg;
        prime_we        = 1'b0;
        prime_waddr     = primes_reg[PAW-1:0];
        prime_wdata     = cur_rd_reg;
        out_fire        = 1'b0;

        case (state_reg)
            pig_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    term_next  = term_value & vmask;
                    last_next  = is_last;
                    k_next     = '0;
                    state_next = pig_pkg::ST_LD_RD;
                end
            end
            pig_pkg::ST_LD_RD:
            begin
                if (k_reg == KW'(cur_count_reg))
                begin
                    state_next = pig_pkg::ST_LD_INS;
                end
                else
                begin
                    state_next = pig_pkg::ST_LD_CMP;
                end
            end
            pig_pkg::ST_LD_CMP:
            begin
                if (cur_rd_reg == {{MAX_VARS{1'b0}}, term_reg})
                begin
                    state_next = pig_pkg::ST_AFTER;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = pig_pkg::ST_LD_RD;
                end
            end
            pig_pkg::ST_LD_INS:
            begin
                if (cur_count_reg < CW'(CUBE_DEPTH))
                begin
                    cur_we         = 1'b1;
                    cur_count_next = cur_count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = pig_pkg::ST_AFTER;
            end
            pig_pkg::ST_AFTER:
            begin
                if (!last_reg)
                begin
                    state_next = pig_pkg::ST_IDLE;
                end
                else
                begin
                    next_count_next = '0;
                    merged_next     = '0;
                    i_next          = '0;
                    state_next      = pig_pkg::ST_RD_I;
                end
            end
            pig_pkg::ST_RD_I:
            begin
                cur_raddr = i_reg[AW-1:0];
                if (i_reg == cur_count_reg)
                begin
                    k_next     = '0;
                    state_next = pig_pkg::ST_EM_RD;
                end
                else
                begin
                    state_next = pig_pkg::ST_LAT_I;
                end
            end
            pig_pkg::ST_LAT_I:
            begin
                a_next     = cur_rd_reg;
                j_next     = i_reg + CW'(1);
                state_next = pig_pkg::ST_RD_J;
            end
            pig_pkg::ST_RD_J:
            begin
                cur_raddr = j_reg[AW-1:0];
                if (j_reg == cur_count_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = pig_pkg::ST_RD_I;
                end
                else
                begin
                    state_next = pig_pkg::ST_CMP_J;
                end
            end
            pig_pkg::ST_CMP_J:
            begin
                if ((a_reg[EW-1:MAX_VARS] == cur_rd_reg[EW-1:MAX_VARS]) && (d != '0)
                    && ((d & (d - MAX_VARS'(1))) == '0))
                begin
                    merged_next[i_reg[AW-1:0]] = 1'b1;
                    merged_next[j_reg[AW-1:0]] = 1'b1;
                    cand_next  = {a_reg[EW-1:MAX_VARS] | d, a_reg[MAX_VARS-1:0] & ~d};
                    k_next     = '0;
                    state_next = pig_pkg::ST_NX_RD;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = pig_pkg::ST_RD_J;
                end
            end
            pig_pkg::ST_NX_RD:
            begin
                if (k_reg == KW'(next_count_reg))
                begin
                    state_next = pig_pkg::ST_NX_INS;
                end
                else
                begin
                    state_next = pig_pkg::ST_NX_CMP;
                end
            end
            pig_pkg::ST_NX_CMP:
            begin
                if (next_rd_reg == cand_reg)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = pig_pkg::ST_RD_J;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = pig_pkg::ST_NX_RD;
                end
            end
            pig_pkg::ST_NX_INS:
            begin
                if (next_count_reg < CW'(CUBE_DEPTH))
                begin
                    next_we         = 1'b1;
                    next_count_next = next_count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                j_next     = j_reg + CW'(1);
                state_next = pig_pkg::ST_RD_J;
            end
            pig_pkg::ST_EM_RD:
            begin
                if (k_reg == KW'(cur_count_reg))
                begin
                    state_next = pig_pkg::ST_ROUND_END;
                end
                else if (merged_reg[k_reg[AW-1:0]])
                begin
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    state_next = pig_pkg::ST_EM_WR;
                end
            end
            pig_pkg::ST_EM_WR:
            begin
                if (primes_reg < PCW'(pig_pkg::OUT_MAX))
                begin
                    prime_we    = 1'b1;
                    primes_next = primes_reg + PCW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                k_next     = k_reg + KW'(1);
                state_next = pig_pkg::ST_EM_RD;
            end
            pig_pkg::ST_ROUND_END:
            begin
                k_next = '0;
                if (next_count_reg == '0)
                begin
                    state_next = pig_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = pig_pkg::ST_CP_RD;
                end
            end
            pig_pkg::ST_CP_RD:
            begin
                if (k_reg == KW'(next_count_reg))
                begin
                    cur_count_next  = next_count_reg;
                    next_count_next = '0;
                    merged_next     = '0;
                    i_next          = '0;
                    state_next      = pig_pkg::ST_RD_I;
                end
                else
                begin
                    state_next = pig_pkg::ST_CP_WR;
                end
            end
            pig_pkg::ST_CP_WR:
            begin
                cur_we     = 1'b1;
                cur_waddr  = k_reg[AW-1:0];
                cur_wdata  = next_rd_reg;
                k_next     = k_reg + KW'(1);
                state_next = pig_pkg::ST_CP_RD;
            end
            pig_pkg::ST_OUT_RD:
            begin
                if (PCW'(k_reg) == primes_reg)
                begin
                    cur_count_next  = '0;
                    next_count_next = '0;
                    primes_next     = '0;
                    ovf_next        = 1'b0;
                    merged_next     = '0;
                    state_next      = pig_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = pig_pkg::ST_OUT_ST;
                end
            end
            pig_pkg::ST_OUT_ST:
            begin
                out_fire   = 1'b1;
                k_next     = k_reg + KW'(1);
                state_next = pig_pkg::ST_OUT_RD;
            end
            default:
            begin
                state_next = pig_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: bench/tb_prime_implicant_generator.sv
// ----------------------------------------------------------------------------
// tb_prime_implicant_generator
// Self-checking bench for the Quine-McCluskey prime implicant generator.
// Term sets are loaded one item at a time. On the last term, a behavioral
// model computes the expected primes, which are checked in order against the
// result strobe. A directed table comes first, then var_count extremes, a
// 70-term set to force overflow and small random sets. var_count is swept
// across its whole range, including out-of-range codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_prime_implicant_generator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV    = pig_pkg::MAX_VARS_DEF;
    localparam int DEPTH = pig_pkg::CUBE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 2000000;

    typedef struct packed {
        logic [NV-1:0] value;
        logic [NV-1:0] mask;
        logic          last;
        logic          ovf;
    } prime_t;

    typedef struct {
        logic [7:0] term;
        logic       last;
        logic       chk;     // typed expectation present
        int         n_exp;
        prime_t     p0;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [NV-1:0]                 term_value;
    logic                          is_last;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pig_pkg::VAR_CFG_W-1:0] cfg_data;
    logic                          result_valid;
    logic [NV-1:0]                 prime_value;
    logic [NV-1:0]                 prime_mask;
    logic                          last_prime;
    logic                          overflow;

    prime_implicant_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .term_value   (term_value),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .prime_value  (prime_value),
        .prime_mask   (prime_mask),
        .last_prime   (last_prime),
        .overflow     (overflow)
    );

    // model state
    logic [3:0]    qm_vars;
    logic [NV-1:0] cube_val[$];
    logic [NV-1:0] cube_msk[$];
    logic          qm_ovf;
    prime_t        prime_q[$];
    int            err_cnt;
    int            idle_cnt;
    int            accepted;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic logic [NV-1:0] term_mask();
        int v;
        v = qm_vars;
        if (v < 1) v = 1;
        if (v > NV) v = NV;
        return NV'((1 << v) - 1);
    endfunction

    // combining rounds on the loaded set; fills prime_q
    task automatic qm_solve();
        logic [NV-1:0] nv_q[$];
        logic [NV-1:0] nm_q[$];
        logic          used[$];
        logic [NV-1:0] d, v, m;
        prime_t        p;
        bit            dup;
        int            first;
        first = prime_q.size();
        forever begin
            nv_q.delete();
            nm_q.delete();
            used.delete();
            foreach (cube_val[i]) used.push_back(1'b0);
            for (int i = 0; i < cube_val.size(); i++)
                for (int j = i + 1; j < cube_val.size(); j++) begin
                    d = cube_val[i] ^ cube_val[j];
                    if (cube_msk[i] != cube_msk[j]) continue;
                    if (d == 0 || (d & (d - 1)) != 0) continue;
                    used[i] = 1'b1;
                    used[j] = 1'b1;
                    v = cube_val[i] & ~d;
                    m = cube_msk[i] | d;
                    dup = 0;
                    foreach (nv_q[k]) if (nv_q[k] == v && nm_q[k] == m) dup = 1;
                    if (dup) continue;
                    if (nv_q.size() < DEPTH) begin
                        nv_q.push_back(v);
                        nm_q.push_back(m);
                    end else
                        qm_ovf = 1'b1;
                end
            foreach (cube_val[i])
                if (!used[i]) begin
                    if (prime_q.size() - first >= pig_pkg::OUT_MAX) qm_ovf = 1'b1;
                    else begin
                        p = '{cube_val[i], cube_msk[i], 1'b0, 1'b0};
                        prime_q.push_back(p);
                    end
                end
            if (nv_q.size() == 0) break;
            cube_val = nv_q;
            cube_msk = nm_q;
        end
        for (int k = first; k < prime_q.size(); k++) prime_q[k].ovf = qm_ovf;
        if (prime_q.size() > first) prime_q[prime_q.size()-1].last = 1'b1;
        cube_val.delete();
        cube_msk.delete();
        qm_ovf = 1'b0;
    endtask

    task automatic qm_load(input logic [7:0] t, input logic lst);
        logic [NV-1:0] tv;
        bit hit;
        tv = t & term_mask();
        hit = 0;
        foreach (cube_val[k]) if (cube_val[k] == tv && cube_msk[k] == 0) hit = 1;
        if (!hit) begin
            if (cube_val.size() < DEPTH) begin
                cube_val.push_back(tv);
                cube_msk.push_back('0);
            end else
                qm_ovf = 1'b1;
        end
        if (lst) qm_solve();
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send(input logic [7:0] t, input logic lst);
        @(negedge clk);
        start      <= 1'b1;
        term_value <= t;
        is_last    <= lst;
        @(posedge clk);
        while (busy) @(posedge clk);
        qm_load(t, lst);
        accepted++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (prime_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_vars(input logic [3:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        qm_vars = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk) begin
        prime_t w;
        if (rst_n && result_valid) begin
            if (prime_q.size() == 0)
                report("unexpected prime", 32'({prime_value, prime_mask}), 32'(0));
            else begin
                w = prime_q.pop_front();
                if (prime_value !== w.value)
                    report("prime_value", 32'(prime_value), 32'(w.value));
                if (prime_mask !== w.mask)
                    report("prime_mask", 32'(prime_mask), 32'(w.mask));
                if (last_prime !== w.last)
                    report("last_prime", 32'(last_prime), 32'(w.last));
                if (overflow !== w.ovf)
                    report("overflow", 32'(overflow), 32'(w.ovf));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("prime_implicant_generator test failed");
            $finish;
        end
    end

    row_t dir_tab[$];

    task automatic add_row(input logic [7:0] t, input logic l, input logic c,
                           input int n, input prime_t p);
        row_t r;
        r = '{t, l, c, n, p};
        dir_tab.push_back(r);
    endtask

    initial begin
        int n;
        logic [7:0] base;
        prime_t none;
        none = '0;
        err_cnt = 0; accepted = 0; qm_ovf = 0;
        qm_vars = pig_pkg::VAR_RESET;
        rst_n = 1'b0; start = 1'b0; term_value = '0; is_last = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single term at reset width: one prime, itself, last
        add_row(8'h0F, 1, 1, 1, '{8'h0F, 8'h00, 1'b1, 1'b0});
        // bits above var_count cleared
        add_row(8'hF5, 1, 1, 1, '{8'h05, 8'h00, 1'b1, 1'b0});
        // pair merging into one dash, duplicate dropped
        add_row(8'h00, 0, 0, 0, none);
        add_row(8'h00, 0, 0, 0, none);
        add_row(8'h01, 1, 1, 1, '{8'h00, 8'h01, 1'b1, 1'b0});
        // full cube of 4 vars
        for (int k = 0; k < 16; k++) add_row(8'(k), k == 15, 0, 0, none);
        foreach (dir_tab[r]) begin
            gap();
            send(dir_tab[r].term, dir_tab[r].last);
            if (dir_tab[r].chk) begin
                if (prime_q.size() != dir_tab[r].n_exp ||
                    prime_q[0] !== dir_tab[r].p0)
                    report("directed row", 32'(r), 32'(0));
            end
        end

        // extremes of var_count, including out-of-range codes
        set_vars(4'd0);
        send(8'hFF, 0); send(8'h00, 1);
        set_vars(4'd15);
        send(8'hFF, 0); send(8'h7F, 1);
        set_vars(4'd8);
        send(8'hAA, 0); send(8'h55, 1);

        // overflow: 70 distinct 8-var terms in a store of 64
        for (int k = 0; k < 70; k++) send(8'(k * 3), k == 69);
        drain();

        // random sets
        while (accepted < 140) begin
            if ($urandom_range(0, 3) == 0) set_vars(4'($urandom_range(0, 15)));
            n = $urandom_range(1, 8);
            base = 8'($urandom);
            for (int k = 0; k < n; k++) begin
                gap();
                if ($urandom_range(0, 3) != 0)
                    send(base ^ 8'(1 << $urandom_range(0, 7)) ^ 8'($urandom_range(0, 3)),
                         k == n - 1);
                else
                    send(8'($urandom), k == n - 1);
            end
            if ($urandom_range(0, 4) == 0) drain();
        end

        drain();
        repeat (100) @(negedge clk);
        if (err_cnt == 0 && prime_q.size() == 0)
            $display("prime_implicant_generator test passed");
        else
            $display("prime_implicant_generator test failed");
        $finish;
    end

endmodule

`default_nettype wire
